// ===== rtl/core/fdss_pkg.sv =====
// Shared types, constants and the digit glyph decoder for the seven-segment scanner.
`timescale 1ns / 1ps

package fdss_pkg;

    localparam int NumberWidth = 14;
    localparam int RepsWidth   = 4;
    localparam int SegWidth    = 7;
    localparam int PlaceCount  = 4;
    localparam int PlaceWidth  = 2;
    localparam int QueueDepth  = 2;

    // Reciprocals for constant division (value * Recip) >> Shift.
    localparam logic [16:0] RecipThou  = 17'd67109;
    localparam int          ShiftThou  = 26;
    localparam logic [5:0]  RecipHund  = 6'd41;
    localparam int          ShiftHund  = 12;
    localparam logic [7:0]  RecipTens  = 8'd205;
    localparam int          ShiftTens  = 11;

    localparam logic [PlaceWidth-1:0] PlaceUnits = 2'd3;
    localparam logic [3:0]            PenNone    = 4'hF;

    typedef enum logic [2:0] {
        F_IDLE,
        F_THOU,
        F_HUND,
        F_TENS,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_BLANK
    } back_state_t;

    // One classified item waiting for the scan sequencer.
    typedef struct packed {
        logic [PlaceCount-1:0][SegWidth-1:0] glyph;
        logic [PlaceWidth-1:0]               first;
        logic                                any;
        logic [RepsWidth-1:0]                reps;
    } fdss_entry_t;

    function automatic logic [SegWidth-1:0] glyph_of(input logic [4:0] digit);
        logic [SegWidth-1:0] seg;
        unique case (digit)
            5'd0:    seg = 7'h3F;
            5'd1:    seg = 7'h06;
            5'd2:    seg = 7'h5B;
            5'd3:    seg = 7'h4F;
            5'd4:    seg = 7'h66;
            5'd5:    seg = 7'h6D;
            5'd6:    seg = 7'h7D;
            5'd7:    seg = 7'h07;
            5'd8:    seg = 7'h7F;
            5'd9:    seg = 7'h6F;
            default: seg = 7'h00;
        endcase
        return seg;
    endfunction

endpackage

// ===== rtl/core/four_digit_seven_segment_scanner.sv =====
// Top level of the four-digit seven-segment scanner.
//
// Input channel (item_valid/item_ready): number (0..16383) and repeat_count.
// Output channel (result_valid/result_ready): segments (a..g, 1 = lit),
// place_enable_n (active low, bit0 thousands .. bit3 units) and last.
// Each input transaction yields repeat_count * shown_places scan results,
// thousands first, with leading zeros blanked, followed by one blanking
// result (segments off, last place select kept, last = 1).
// The front end handles a transaction in steps (accept, three digit
// extraction steps and a queue push); the back end loads an item and then
// delivers one result per cycle while the result register is free.
// On an empty pipeline the first result follows the front-end steps, the
// queue push, the back-end load and the result register write.
// A two-entry queue decouples the two ends; the front end keeps
// accepting while the back end scans until the queue fills.
// While a valid result waits on result_ready the result register holds and
// the back end stalls; the front end stalls only once the queue is full.
// Reset empties the queue, clears all valids and sets the held place
// select to all ones (no place selected).
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner
    import fdss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [NumberWidth-1:0] number,
    input  logic [RepsWidth-1:0]   repeat_count,
    output logic                   result_valid,
    input  logic                   result_ready,
    output logic [SegWidth-1:0]    segments,
    output logic [3:0]             place_enable_n,
    output logic                   last
);

    logic        push;
    logic        pop;
    logic        queue_full;
    logic        queue_empty;
    fdss_entry_t push_entry;
    fdss_entry_t pop_entry;

    fdss_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .number       (number),
        .repeat_count (repeat_count),
        .push         (push),
        .push_entry   (push_entry),
        .queue_full   (queue_full)
    );

    fdss_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (queue_empty)
    );

    fdss_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_empty    (queue_empty),
        .pop_entry      (pop_entry),
        .pop            (pop),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .segments       (segments),
        .place_enable_n (place_enable_n),
        .last           (last)
    );

endmodule

// ===== rtl/core/fdss_front.sv =====
// Front end: accepts a transaction, splits the number into digit glyphs, queues the result.
`timescale 1ns / 1ps

module fdss_front
    import fdss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_ready,
    input  logic [NumberWidth-1:0] number,
    input  logic [RepsWidth-1:0]   repeat_count,
    output logic                   push,
    output fdss_entry_t            push_entry,
    input  logic                   queue_full
);

    front_state_t state_reg, state_next;

    logic [NumberWidth-1:0]              val_reg, val_next;
    logic [RepsWidth-1:0]                reps_reg, reps_next;
    logic [PlaceWidth-1:0]               first_reg, first_next;
    logic                                any_reg, any_next;
    logic [PlaceCount-1:0][SegWidth-1:0] glyph_reg, glyph_next;

    logic [30:0] prod_thou;
    logic [4:0]  thou;
    logic [15:0] prod_hund;
    logic [3:0]  hund;
    logic [14:0] prod_tens;
    logic [3:0]  tens;
    logic [3:0]  units;
    logic [PlaceWidth-1:0] first_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        reps_reg  <= reps_next;
        first_reg <= first_next;
        any_reg   <= any_next;
        glyph_reg <= glyph_next;
    end

    // Leading place shown; leading zeros are blanked.
    always_comb
    begin
        if (number >= 14'd1000)
        begin
            first_in = 2'd0;
        end
        else if (number >= 14'd100)
        begin
            first_in = 2'd1;
        end
        else if (number >= 14'd10)
        begin
            first_in = 2'd2;
        end
        else
        begin
            first_in = 2'd3;
        end
    end

    always_comb
    begin
        prod_thou = 31'(val_reg * RecipThou);
        thou      = prod_thou[ShiftThou +: 5];
        prod_hund = 16'(val_reg[9:0] * RecipHund);
        hund      = prod_hund[ShiftHund +: 4];
        prod_tens = 15'(val_reg[6:0] * RecipTens);
        tens      = prod_tens[ShiftTens +: 4];
        units     = 4'(val_reg[6:0] - 7'(tens * 7'd10));
    end

    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        reps_next  = reps_reg;
        first_next = first_reg;
        any_next   = any_reg;
        glyph_next = glyph_reg;
        item_ready = 1'b0;
        push       = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    val_next   = number;
                    reps_next  = repeat_count;
                    first_next = first_in;
                    any_next   = (number != '0);
                    state_next = F_THOU;
                end
            end
            F_THOU:
            begin
                glyph_next[0] = glyph_of(thou);
                val_next      = 14'(val_reg - 14'(thou * 14'd1000));
                state_next    = F_HUND;
            end
            F_HUND:
            begin
                glyph_next[1] = glyph_of({1'b0, hund});
                val_next      = 14'(val_reg[9:0] - 10'(hund * 10'd100));
                state_next    = F_TENS;
            end
            F_TENS:
            begin
                glyph_next[2] = glyph_of({1'b0, tens});
                glyph_next[3] = glyph_of({1'b0, units});
                state_next    = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push_entry.glyph = glyph_reg;
        push_entry.first = first_reg;
        push_entry.any   = any_reg;
        push_entry.reps  = reps_reg;
    end

endmodule

// ===== rtl/core/fdss_queue.sv =====
// Short FIFO of classified items between the front end and the scan sequencer.
`timescale 1ns / 1ps

module fdss_queue
    import fdss_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  fdss_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output fdss_entry_t pop_entry,
    output logic        empty
);

    localparam int PtrWidth   = $clog2(QueueDepth);
    localparam int CountWidth = $clog2(QueueDepth + 1);

    fdss_entry_t           slot_reg [QueueDepth];
    logic [PtrWidth-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CountWidth-1:0] count_reg;

    assign full      = (count_reg == CountWidth'(QueueDepth));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0
                                                                         : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(QueueDepth - 1)) ? '0
                                                                         : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/fdss_back.sv =====
// Back end: walks the shown places for each repeat and drives the result register.
`timescale 1ns / 1ps

module fdss_back
    import fdss_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                queue_empty,
    input  fdss_entry_t         pop_entry,
    output logic                pop,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [SegWidth-1:0] segments,
    output logic [3:0]          place_enable_n,
    output logic                last
);

    back_state_t state_reg, state_next;

    logic [PlaceWidth-1:0]               place_reg, place_next;
    logic [PlaceWidth-1:0]               first_reg, first_next;
    logic [RepsWidth-1:0]                rep_reg, rep_next;
    logic [PlaceCount-1:0][SegWidth-1:0] glyph_reg, glyph_next;
    logic [3:0]                          held_reg, held_next;

    logic                out_valid_reg, out_valid_next;
    logic [SegWidth-1:0] seg_reg, seg_next;
    logic [3:0]          pen_reg, pen_next;
    logic                last_reg, last_next;

    logic slot_free;

    assign slot_free      = !out_valid_reg || result_ready;
    assign result_valid   = out_valid_reg;
    assign segments       = seg_reg;
    assign place_enable_n = pen_reg;
    assign last           = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            held_reg      <= PenNone;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        place_reg <= place_next;
        first_reg <= first_next;
        rep_reg   <= rep_next;
        glyph_reg <= glyph_next;
        seg_reg   <= seg_next;
        pen_reg   <= pen_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        place_next     = place_reg;
        first_next     = first_reg;
        rep_next       = rep_reg;
        glyph_next     = glyph_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        seg_next       = seg_reg;
        pen_next       = pen_reg;
        last_next      = last_reg;
        pop            = 1'b0;

        if (result_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!queue_empty)
                begin
                    pop        = 1'b1;
                    glyph_next = pop_entry.glyph;
                    first_next = pop_entry.first;
                    place_next = pop_entry.first;
                    rep_next   = pop_entry.reps;
                    state_next = (pop_entry.any && pop_entry.reps != '0) ? B_SCAN : B_BLANK;
                end
            end
            B_SCAN:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    seg_next       = glyph_reg[place_reg];
                    pen_next       = ~(4'b0001 << place_reg);
                    last_next      = 1'b0;
                    held_next      = ~(4'b0001 << place_reg);
                    if (place_reg == PlaceUnits)
                    begin
                        place_next = first_reg;
                        rep_next   = rep_reg - 1'b1;
                        if (rep_reg == RepsWidth'(1))
                        begin
                            state_next = B_BLANK;
                        end
                    end
                    else
                    begin
                        place_next = place_reg + 1'b1;
                    end
                end
            end
            B_BLANK:
            begin
                // held_reg holds the place select of the most recent scan result
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    seg_next       = '0;
                    pen_next       = held_reg;
                    last_next      = 1'b1;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

endmodule

// ===== test/scan_result_checker.sv =====
// Result checker for the seven-segment scanner: predicts scan results per input and compares them.
`timescale 1ns / 1ps

module scan_result_checker
    import fdss_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  logic [NumberWidth-1:0] number,
    input  logic [RepsWidth-1:0]   repeat_count,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  logic [SegWidth-1:0]    segments,
    input  logic [3:0]             place_enable_n,
    input  logic                   last,
    output int                     fail_count,
    output int                     due_count,
    output int                     items_seen,
    output int                     results_seen
);

    typedef struct packed {
        logic [SegWidth-1:0] segments;
        logic [3:0]          place_enable_n;
        logic                last;
    } scan_result_t;

    scan_result_t due_scans[$];
    logic [3:0]   held_pen = PenNone;
    int           fails    = 0;
    int           pending  = 0;
    int           n_items  = 0;
    int           n_scans  = 0;

    assign fail_count   = fails;
    assign due_count    = pending;
    assign items_seen   = n_items;
    assign results_seen = n_scans;

    function automatic logic [SegWidth-1:0] digit_glyph(input int digit);
        case (digit)
            0:       return 7'h3F;
            1:       return 7'h06;
            2:       return 7'h5B;
            3:       return 7'h4F;
            4:       return 7'h66;
            5:       return 7'h6D;
            6:       return 7'h7D;
            7:       return 7'h07;
            8:       return 7'h7F;
            9:       return 7'h6F;
            default: return 7'h00;  // thousands digit of an out-of-range number
        endcase
    endfunction

    // Queue up every result one input transaction should produce.
    task automatic predict_scan(input int num, input int reps);
        int           digit [PlaceCount];
        bit           shown [PlaceCount];
        scan_result_t res;
        digit[0] = num / 1000;
        digit[1] = (num / 100) % 10;
        digit[2] = (num / 10) % 10;
        digit[3] = num % 10;
        shown[0] = num >= 1000;
        shown[1] = num >= 100;
        shown[2] = num >= 10;
        shown[3] = num >= 1;
        for (int r = 0; r < reps; r++) begin
            for (int p = 0; p < PlaceCount; p++) begin
                if (shown[p]) begin
                    held_pen = 4'hF & ~(4'b0001 << p);
                    res.segments       = digit_glyph(digit[p]);
                    res.place_enable_n = held_pen;
                    res.last           = 1'b0;
                    due_scans.push_back(res);
                end
            end
        end
        // blanking result keeps whatever place select was driven last
        res.segments       = '0;
        res.place_enable_n = held_pen;
        res.last           = 1'b1;
        due_scans.push_back(res);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        scan_result_t want;
        if (!rst_n)
        begin
            due_scans.delete();
            held_pen = PenNone;
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                predict_scan(int'(number), int'(repeat_count));
                n_items++;
            end
            if (result_valid && result_ready)
            begin
                n_scans++;
                if (due_scans.size() == 0)
                begin
                    $display("%0t: unexpected result seg=%h pen=%h last=%b",
                             $time, segments, place_enable_n, last);
                    fails++;
                end
                else
                begin
                    want = due_scans.pop_front();
                    if (want.segments !== segments || want.place_enable_n !== place_enable_n
                        || want.last !== last)
                    begin
                        $display("%0t: exp seg=%h pen=%h last=%b, got seg=%h pen=%h last=%b",
                                 $time, want.segments, want.place_enable_n, want.last,
                                 segments, place_enable_n, last);
                        fails++;
                    end
                end
            end
        end
        pending = due_scans.size();
    end

endmodule

// ===== test/four_digit_seven_segment_scanner_tb.sv =====
// Testbench top for the seven-segment scanner: clock, reset, stimulus, pacing and verdict.
`timescale 1ns / 1ps

module four_digit_seven_segment_scanner_tb;
    import fdss_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_ready;
    logic [NumberWidth-1:0] number;
    logic [RepsWidth-1:0]   repeat_count;
    logic                   result_valid;
    logic                   result_ready;
    logic [SegWidth-1:0]    segments;
    logic [3:0]             place_enable_n;
    logic                   last;

    int fail_count;
    int due_count;
    int items_seen;
    int results_seen;

    int phase    = 0;
    int send_pct = 37;
    int recv_pct = 72;

    four_digit_seven_segment_scanner u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .number         (number),
        .repeat_count   (repeat_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .segments       (segments),
        .place_enable_n (place_enable_n),
        .last           (last)
    );

    scan_result_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .number         (number),
        .repeat_count   (repeat_count),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .segments       (segments),
        .place_enable_n (place_enable_n),
        .last           (last),
        .fail_count     (fail_count),
        .due_count      (due_count),
        .items_seen     (items_seen),
        .results_seen   (results_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // Receiver pacing; in the last phase it first holds off long enough to back up the input.
    initial
    begin : receiver
        int hold_left;
        bit held_done;
        hold_left    = 0;
        held_done    = 1'b0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                result_ready <= 1'b0;
                hold_left--;
            end
            else if (phase == 2 && !held_done)
            begin
                held_done    = 1'b1;
                hold_left    = 400;
                result_ready <= 1'b0;
            end
            else
                result_ready <= ($urandom_range(0, 99) >= recv_pct);
        end
    end

    function automatic logic [NumberWidth-1:0] rand_number();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return NumberWidth'($urandom_range(1, 9));
            2:       return NumberWidth'($urandom_range(10, 99));
            3:       return NumberWidth'($urandom_range(100, 999));
            7:       return NumberWidth'($urandom_range(10000, 16383));
            8:       return NumberWidth'($urandom);
            9:
                case ($urandom_range(0, 7))
                    0:       return 14'd9;
                    1:       return 14'd10;
                    2:       return 14'd99;
                    3:       return 14'd100;
                    4:       return 14'd999;
                    5:       return 14'd1000;
                    6:       return 14'd9999;
                    default: return 14'd10000;
                endcase
            default: return NumberWidth'($urandom_range(1000, 9999));
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(input logic [NumberWidth-1:0] num, input logic [RepsWidth-1:0] reps);
        if ($urandom_range(0, 99) < send_pct)
        begin
            item_valid = 1'b0;
            do @(negedge clk); while ($urandom_range(0, 99) < send_pct);
        end
        item_valid   = 1'b1;
        number       = num;
        repeat_count = reps;
        do @(posedge clk); while (!item_ready);
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        item_valid   = 1'b0;
        number       = '0;
        repeat_count = '0;
        rst_n        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // blank-only cases first so the reset place select is seen
        send_item(14'd0, 4'd0);
        send_item(14'd0, 4'd15);
        send_item(14'd5, 4'd0);
        send_item(14'd1, 4'd1);
        send_item(14'd9, 4'd2);
        send_item(14'd10, 4'd1);
        send_item(14'd99, 4'd3);
        send_item(14'd100, 4'd1);
        send_item(14'd999, 4'd1);
        send_item(14'd1000, 4'd1);
        send_item(14'd1234, 4'd2);
        send_item(14'd5678, 4'd1);
        send_item(14'd9012, 4'd1);
        send_item(14'd9999, 4'd15);
        send_item(14'd0, 4'd3);
        send_item(14'd9999, 4'd0);
        send_item(14'd10000, 4'd1);
        send_item(14'd16383, 4'd1);
        send_item(14'd16383, 4'd15);
        send_item(14'd12345, 4'd2);
        send_item(14'd3050, 4'd1);
        send_item(14'd7, 4'd15);
        send_item(14'd2468, 4'd4);

        for (int n = 0; n < 200; n++)
        begin
            if (n == 67)
            begin
                phase    = 1;
                send_pct = 72;
                recv_pct = 37;
            end
            if (n == 134)
            begin
                phase    = 2;
                send_pct = 0;
                recv_pct = 0;
            end
            send_item(rand_number(),
                      ($urandom_range(0, 9) == 0) ? 4'd0 : RepsWidth'($urandom_range(0, 15)));
        end
        item_valid = 1'b0;

        while (due_count != 0) @(negedge clk);
        repeat (80) @(negedge clk);

        $display("Covered %0d input transactions and %0d result transactions", items_seen,
                 results_seen);
        $display("over three pacing phases, blanked and out-of-range numbers, one long stall");
        if (fail_count == 0 && due_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/fdss_pkg.sv
rtl/core/fdss_front.sv
rtl/core/fdss_queue.sv
rtl/core/fdss_back.sv
rtl/core/four_digit_seven_segment_scanner.sv
test/scan_result_checker.sv
test/four_digit_seven_segment_scanner_tb.sv
